// File: src/pid_position_regulator_macros.svh
// Assertion macros shared by the PID position regulator modules.
// No dependencies; included by the files that carry assertions.
`ifndef PID_POSITION_REGULATOR_MACROS_SVH
`define PID_POSITION_REGULATOR_MACROS_SVH

// Same-cycle implication, reset disables the check
`define PIDPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset disables the check
`define PIDPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pidpr_pkg.sv
// Shared constants and types of the PID position regulator.
// No dependencies; used by every module of the block.
package pidpr_pkg;

	// fixed-point format and field widths
	localparam int FRAC_BITS  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IN_W       = 32;
	localparam int ERR_W      = IN_W + 1;
	localparam int GAIN_W     = 32;
	localparam int CLIM_W     = 31;
	localparam int ILIM_W     = 47;
	localparam int INTEG_W    = 48;
	localparam int INT_SPLIT  = INTEG_W / 2;
	localparam int PROD_W     = GAIN_W + ERR_W;
	localparam int ACC_W      = GAIN_W + INTEG_W + 2;
	localparam int SHR_W      = ACC_W - FRAC_BITS;
	localparam int CFG_W      = ILIM_W;
	localparam int CFG_IDX_W  = 3;
	localparam int QDEPTH     = 2;

	// largest command magnitude the data width can carry
	localparam logic [CLIM_W-1:0] CMD_MAX =
		CLIM_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

	// 48-bit signed range of the integral, held one bit wider
	localparam logic signed [INTEG_W:0] INTEG_MAX = {2'b00, {(INTEG_W - 1){1'b1}}};
	localparam logic signed [INTEG_W:0] INTEG_MIN = {2'b11, {(INTEG_W - 1){1'b0}}};

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP      = 3'd0,
		REG_GAIN_INTEG     = 3'd1,
		REG_GAIN_DERIV     = 3'd2,
		REG_COMMAND_LIMIT  = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_LOOP_ENABLE    = 3'd5,
		REG_ADD_PREVIOUS   = 3'd6,
		REG_VARIANT        = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_prop;
		logic signed [GAIN_W-1:0] gain_integ;
		logic signed [GAIN_W-1:0] gain_deriv;
		logic [CLIM_W-1:0]        command_limit;
		logic [ILIM_W-1:0]        integral_limit;
		logic                     loop_enable;
		logic                     add_previous;
		logic                     variant;
	} cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [ERR_W-1:0]   deriv;
		logic signed [INTEG_W-1:0] integ;
	} q_entry_t;

	// push side of the queue
	typedef struct packed {
		logic     push;
		q_entry_t data;
	} q_wr_t;

	// read side of the queue
	typedef struct packed {
		logic     valid;
		q_entry_t head;
	} q_rd_t;

endpackage

// File: src/pid_position_regulator.sv
// Top level of the PID position regulator: configuration registers and
// the front, queue and back. Depends on pidpr_pkg and all pidpr_* modules.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------
//  in      | in_valid / in_stall    | setpoint, measurement
//  out     | out_valid / out_stall  | command
//  cfg     | cfg_write              | cfg_index, cfg_data
//
// In the back one shared 32x33 multiplier forms the proportional,
// derivative and two integral partial products of each word in turn.
// Each word is queued, its products registered, then its command.
// The front accepts a word every cycle while the two-entry queue has room.
// An output stall freezes only the back; reset clears control state only.
module pid_position_regulator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [pidpr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidpr_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [pidpr_pkg::IN_W-1:0]      setpoint,
	input  logic signed [pidpr_pkg::IN_W-1:0]      measurement,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pidpr_pkg::IN_W-1:0]      command
);

	pidpr_pkg::cfg_t  cfg_q;
	pidpr_pkg::q_wr_t q_wr;
	pidpr_pkg::q_rd_t q_rd;
	logic             q_full;
	logic             q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (pidpr_pkg::cfg_reg_t'(cfg_index))
				pidpr_pkg::REG_GAIN_PROP:
					cfg_q.gain_prop <= cfg_data[pidpr_pkg::GAIN_W-1:0];
				pidpr_pkg::REG_GAIN_INTEG:
					cfg_q.gain_integ <= cfg_data[pidpr_pkg::GAIN_W-1:0];
				pidpr_pkg::REG_GAIN_DERIV:
					cfg_q.gain_deriv <= cfg_data[pidpr_pkg::GAIN_W-1:0];
				pidpr_pkg::REG_COMMAND_LIMIT:
					cfg_q.command_limit <= cfg_data[pidpr_pkg::CLIM_W-1:0];
				pidpr_pkg::REG_INTEGRAL_LIMIT:
					cfg_q.integral_limit <= cfg_data[pidpr_pkg::ILIM_W-1:0];
				pidpr_pkg::REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_data[0];
				pidpr_pkg::REG_ADD_PREVIOUS: cfg_q.add_previous <= cfg_data[0];
				pidpr_pkg::REG_VARIANT:      cfg_q.variant      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pidpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.setpoint    (setpoint),
		.measurement (measurement),
		.q_full      (q_full),
		.q_wr        (q_wr)
	);

	pidpr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.q_rd   (q_rd)
	);

	pidpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_rd      (q_rd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command)
	);

endmodule

// File: src/pidpr_front.sv
// Front end: forms the error, updates the integral and the derivative.
// Depends on pidpr_pkg; feeds pidpr_queue.
module pidpr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pidpr_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pidpr_pkg::IN_W-1:0]   setpoint,
	input  logic signed [pidpr_pkg::IN_W-1:0]   measurement,
	input  logic                                q_full,
	output pidpr_pkg::q_wr_t                    q_wr
);

	logic signed [pidpr_pkg::INTEG_W-1:0] integ_q;
	logic signed [pidpr_pkg::IN_W-1:0]    prev_meas_q;

	logic signed [pidpr_pkg::ERR_W-1:0]   err;
	logic signed [pidpr_pkg::ERR_W-1:0]   deriv;
	logic signed [pidpr_pkg::INTEG_W:0]   isum;
	logic signed [pidpr_pkg::INTEG_W:0]   ilim_pos;
	logic signed [pidpr_pkg::INTEG_W:0]   ilim_neg;
	logic signed [pidpr_pkg::INTEG_W:0]   isat;
	logic                                 accept;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	// error, derivative and raw integral
	always_comb begin
		err = $signed({setpoint[pidpr_pkg::IN_W-1], setpoint})
			- $signed({measurement[pidpr_pkg::IN_W-1], measurement});
		if (cfg.variant) begin
			deriv = $signed({measurement[pidpr_pkg::IN_W-1], measurement})
				- $signed({prev_meas_q[pidpr_pkg::IN_W-1], prev_meas_q});
		end else begin
			deriv = $signed({prev_meas_q[pidpr_pkg::IN_W-1], prev_meas_q})
				- $signed({measurement[pidpr_pkg::IN_W-1], measurement});
		end
		isum = $signed({integ_q[pidpr_pkg::INTEG_W-1], integ_q})
			+ $signed({{(pidpr_pkg::INTEG_W + 1 - pidpr_pkg::ERR_W){err[pidpr_pkg::ERR_W-1]}},
				err});
		ilim_pos = $signed({2'b00, cfg.integral_limit});
		ilim_neg = -ilim_pos;
	end

	// anti-windup clamp, or plain saturation at the register range
	always_comb begin
		if (!cfg.variant) begin
			if (isum > ilim_pos) begin
				isat = ilim_pos;
			end else if (isum < ilim_neg) begin
				isat = ilim_neg;
			end else begin
				isat = isum;
			end
			// integral opposing the error is dropped
			if (!err[pidpr_pkg::ERR_W-1] && (|err) && isat[pidpr_pkg::INTEG_W]) begin
				isat = '0;
			end
			if (err[pidpr_pkg::ERR_W-1] && !isat[pidpr_pkg::INTEG_W] && (|isat)) begin
				isat = '0;
			end
		end else begin
			if (isum > pidpr_pkg::INTEG_MAX) begin
				isat = pidpr_pkg::INTEG_MAX;
			end else if (isum < pidpr_pkg::INTEG_MIN) begin
				isat = pidpr_pkg::INTEG_MIN;
			end else begin
				isat = isum;
			end
		end
	end

	// loop state, advanced on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_meas_q <= '0;
		end else if (accept) begin
			integ_q     <= isat[pidpr_pkg::INTEG_W-1:0];
			prev_meas_q <= measurement;
		end
	end

	assign q_wr.push       = accept;
	assign q_wr.data.err   = err;
	assign q_wr.data.deriv = deriv;
	assign q_wr.data.integ = isat[pidpr_pkg::INTEG_W-1:0];

endmodule

// File: src/pidpr_queue.sv
// Short queue of classified words between front and back.
// Depends on pidpr_pkg and the assertion macro header.
`include "pid_position_regulator_macros.svh"

module pidpr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  pidpr_pkg::q_wr_t q_wr,
	output logic             full,
	input  logic             pop,
	output pidpr_pkg::q_rd_t q_rd
);

	localparam int PTR_W = $clog2(pidpr_pkg::QDEPTH);
	localparam int CNT_W = $clog2(pidpr_pkg::QDEPTH + 1);

	pidpr_pkg::q_entry_t mem_q [pidpr_pkg::QDEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full       = (count_q == CNT_W'(pidpr_pkg::QDEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(pidpr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(pidpr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !q_wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PIDPR_ASSERT_IMPL(a_no_push_full, clk, arst_n, q_wr.push, !full, "push into full queue")
	`PIDPR_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, count_q != '0, "pop from empty queue")

endmodule

// File: src/pidpr_back.sv
// Back end: gain products over a shared multiplier, sum, shift and clamp.
// Depends on pidpr_pkg and the assertion macro header; drains pidpr_queue.
`include "pid_position_regulator_macros.svh"

module pidpr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidpr_pkg::cfg_t                   cfg,
	input  pidpr_pkg::q_rd_t                  q_rd,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pidpr_pkg::IN_W-1:0] command
);

	// which partial product the multiplier forms this cycle
	typedef enum logic [3:0] {
		STEP_PROP  = 4'b0001,
		STEP_DERIV = 4'b0010,
		STEP_ILO   = 4'b0100,
		STEP_IHI   = 4'b1000
	} step_t;

	localparam int HI_W = pidpr_pkg::INTEG_W - pidpr_pkg::INT_SPLIT;

	step_t                                  step_q;
	step_t                                  prod_step_s1;
	logic                                   prod_vld_s1;
	logic signed [pidpr_pkg::PROD_W-1:0]    prod_s1;
	logic signed [pidpr_pkg::ACC_W-1:0]     acc_q;
	logic signed [pidpr_pkg::IN_W-1:0]      prev_cmd_q;
	logic                                   out_valid_q;
	logic signed [pidpr_pkg::IN_W-1:0]      command_q;

	logic                                   fin;
	logic                                   adv;
	logic                                   issue;
	logic                                   out_load;
	logic signed [pidpr_pkg::GAIN_W-1:0]    mul_a;
	logic signed [pidpr_pkg::ERR_W-1:0]     mul_b;
	logic signed [pidpr_pkg::PROD_W-1:0]    prod_next;
	logic [HI_W-1:0]                        integ_hi;
	logic signed [pidpr_pkg::ACC_W-1:0]     p_ext;
	logic signed [pidpr_pkg::ACC_W-1:0]     p_aln;
	logic signed [pidpr_pkg::ACC_W-1:0]     prev_term;
	logic signed [pidpr_pkg::ACC_W-1:0]     sum;
	logic signed [pidpr_pkg::SHR_W-1:0]     shr;
	logic [pidpr_pkg::CLIM_W-1:0]           lim;
	logic signed [pidpr_pkg::SHR_W-1:0]     lim_pos;
	logic signed [pidpr_pkg::SHR_W-1:0]     lim_neg;
	logic signed [pidpr_pkg::SHR_W-1:0]     clamped;
	logic signed [pidpr_pkg::IN_W-1:0]      cmd_next;

	// flow control: a final word held by a stalled output freezes the back
	assign fin      = prod_vld_s1 && (prod_step_s1 == STEP_IHI);
	assign adv      = !(fin && out_valid_q && out_stall);
	assign issue    = adv && q_rd.valid;
	assign q_pop    = issue && (step_q == STEP_IHI);
	assign out_load = adv && fin;

	// operand select for the shared multiplier
	assign integ_hi = q_rd.head.integ[pidpr_pkg::INTEG_W-1:pidpr_pkg::INT_SPLIT];
	always_comb begin
		unique case (step_q)
			STEP_PROP: begin
				mul_a = cfg.gain_prop;
				mul_b = q_rd.head.err;
			end
			STEP_DERIV: begin
				mul_a = cfg.gain_deriv;
				mul_b = q_rd.head.deriv;
			end
			STEP_ILO: begin
				mul_a = cfg.gain_integ;
				mul_b = $signed({{(pidpr_pkg::ERR_W - pidpr_pkg::INT_SPLIT){1'b0}},
					q_rd.head.integ[pidpr_pkg::INT_SPLIT-1:0]});
			end
			STEP_IHI: begin
				mul_a = cfg.gain_integ;
				mul_b = $signed({{(pidpr_pkg::ERR_W - HI_W){integ_hi[HI_W-1]}}, integ_hi});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_next = mul_a * mul_b;

	// align the registered product; upper integral half sits INT_SPLIT up
	always_comb begin
		p_ext = $signed({{(pidpr_pkg::ACC_W - pidpr_pkg::PROD_W){prod_s1[pidpr_pkg::PROD_W-1]}},
			prod_s1});
		p_aln = (prod_step_s1 == STEP_IHI) ? (p_ext <<< pidpr_pkg::INT_SPLIT) : p_ext;
	end

	// final sum, floor shift and clamp
	always_comb begin
		if (!cfg.variant && cfg.add_previous) begin
			prev_term = $signed({{(pidpr_pkg::ACC_W - pidpr_pkg::IN_W){prev_cmd_q[pidpr_pkg::IN_W-1]}},
				prev_cmd_q}) <<< pidpr_pkg::FRAC_BITS;
		end else begin
			prev_term = '0;
		end
		sum     = acc_q + p_aln + prev_term;
		shr     = sum[pidpr_pkg::ACC_W-1:pidpr_pkg::FRAC_BITS];
		lim     = (cfg.command_limit < pidpr_pkg::CMD_MAX) ? cfg.command_limit
			: pidpr_pkg::CMD_MAX;
		lim_pos = $signed({{(pidpr_pkg::SHR_W - pidpr_pkg::CLIM_W){1'b0}}, lim});
		lim_neg = -lim_pos;
		if (shr > lim_pos) begin
			clamped = lim_pos;
		end else if (shr < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = shr;
		end
		cmd_next = cfg.loop_enable ? clamped[pidpr_pkg::IN_W-1:0] : '0;
	end

	// sequencer, product tag, previous command and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_PROP;
			prod_vld_s1  <= 1'b0;
			prod_step_s1 <= STEP_PROP;
			prev_cmd_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (issue) begin
				unique case (step_q)
					STEP_PROP:  step_q <= STEP_DERIV;
					STEP_DERIV: step_q <= STEP_ILO;
					STEP_ILO:   step_q <= STEP_IHI;
					STEP_IHI:   step_q <= STEP_PROP;
					default:    step_q <= STEP_PROP;
				endcase
			end
			if (adv) begin
				prod_vld_s1  <= issue;
				prod_step_s1 <= step_q;
			end
			if (out_load) begin
				prev_cmd_q  <= cmd_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_next;
		end
		if (adv && prod_vld_s1) begin
			if (prod_step_s1 == STEP_PROP) begin
				acc_q <= p_aln;
			end else if (prod_step_s1 != STEP_IHI) begin
				acc_q <= acc_q + p_aln;
			end
		end
		if (out_load) begin
			command_q <= cmd_next;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;

	`PIDPR_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_load, !(out_valid_q && out_stall), "output word overwritten while stalled")
	`PIDPR_ASSERT_NEXT(a_pop_to_final, clk, arst_n, q_pop, prod_vld_s1 && (prod_step_s1 == STEP_IHI), "popped word did not reach the final product")

endmodule
